// ===== sv/pfta_pkg.sv =====
package pfta_pkg;

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int OCC_W   = 5;
  localparam int IDX_W   = 4;
  localparam int STAMP_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [OCC_W-1:0]   MAX_OCC_RESET = 5'd16;
  localparam logic [STAMP_W-1:0] STAMP_RESET   = 32'd1;

  typedef struct packed {
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic               refused;
    logic               hit;
    logic               allocated;
    logic [IDX_W-1:0]   frame_index;
    logic [COUNT_W-1:0] fault_count;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

endpackage

// ===== sv/pfta_ram.sv =====
module pfta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/page_frame_table_allocator.sv =====
// Channel   Dir  Handshake             Payload
// req       in   req_valid/req_stall   pfta_pkg::req_t (process_id, page_number)
// rsp       out  rsp_valid/rsp_stall   pfta_pkg::rsp_t (refused .. occupancy)
// cfg       in   cfg_we                cfg_data = max_occupancy
//
// One request at a time. The frame table is read one entry a cycle up to the
// first hit (skipped when refused or the table is empty). Then every fault
// table slot is read one a cycle, and the RAM read port sets the pace.
// Reset (rst, synchronous) clears the occupancy count and the slot valid bits;
// no clearing pass. Frames past the occupancy count are never read.
// A held response in the output register does not block the next request;
// only the write-back waits for the output register to drain.
module page_frame_table_allocator #(
  parameter int FRAME_COUNT   = 16,
  parameter int PROCESS_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pfta_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pfta_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data
);

  import pfta_pkg::*;

  localparam int FAW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int SAW  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int OCW0 = $clog2(FRAME_COUNT + 1);
  localparam int OCW  = (OCW0 > OCC_W) ? OCW0 : OCC_W;
  localparam int SCW  = $clog2(PROCESS_SLOTS + 1);
  localparam int IXW  = (FAW > IDX_W) ? FAW : IDX_W;
  localparam int FW   = PID_W + PAGE_W;
  localparam int TW   = PID_W + COUNT_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;   // walk used frames for a hit
  localparam logic [1:0] ST_SLOT  = 2'd2;   // walk fault table slots
  localparam logic [1:0] ST_DONE  = 2'd3;   // write back, load response

  logic [1:0]         state;
  logic [PID_W-1:0]   pid;
  logic [PAGE_W-1:0]  page;
  logic               refuse;
  logic               hit;
  logic [FAW-1:0]     hit_idx;

  logic [OCW-1:0]     occ;
  logic [OCC_W-1:0]   max_occ;
  logic [STAMP_W-1:0] stamp;

  // frame walk: read issued at f_issue, compared in the next cycle
  logic [OCW-1:0]     f_issue;
  logic               f_pend;
  logic [FAW-1:0]     f_pidx;
  logic               f_rd;

  // slot walk
  logic [SCW-1:0]     s_issue;
  logic               s_pend;
  logic [SAW-1:0]     s_pidx;
  logic               s_pval;
  logic               s_rd;
  logic [PROCESS_SLOTS-1:0] slot_valid;

  // first slot owned by pid, first empty slot
  logic               own_hit;
  logic [SAW-1:0]     own_idx;
  logic [COUNT_W-1:0] own_total;
  logic               emp_hit;
  logic [SAW-1:0]     emp_idx;
  logic [COUNT_W-1:0] emp_total;

  logic [FW-1:0]      fr_rdata;
  logic [TW-1:0]      sl_rdata;
  logic [PID_W-1:0]   sl_owner;
  logic [COUNT_W-1:0] sl_total;

  logic               rsp_free;
  logic               commit;
  logic               served;
  logic               fault;
  logic               alloc;
  logic               slot_ok;
  logic [SAW-1:0]     use_slot;
  logic [COUNT_W-1:0] base_total;
  logic [COUNT_W-1:0] inc_total;
  logic [COUNT_W-1:0] count_out;
  logic [IXW-1:0]     idx_out;
  logic               refuse_now;

  assign req_stall  = (state != ST_IDLE);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign refuse_now = (occ >= OCW'(max_occ));

  assign f_rd = (state == ST_FRAME) && (f_issue < occ) && !hit;
  assign s_rd = (state == ST_SLOT) && (s_issue < SCW'(PROCESS_SLOTS));

  // never-written slots read as empty (owner 0, count 0)
  assign sl_owner = s_pval ? sl_rdata[TW-1:COUNT_W] : '0;
  assign sl_total = s_pval ? sl_rdata[COUNT_W-1:0]  : '0;

  // write-back decisions
  assign commit     = (state == ST_DONE) && rsp_free;
  assign served     = !refuse;
  assign fault      = served && !hit;
  assign alloc      = fault && (occ < OCW'(FRAME_COUNT));
  assign slot_ok    = own_hit || emp_hit;
  assign use_slot   = own_hit ? own_idx : emp_idx;
  assign base_total = own_hit ? own_total : emp_total;
  assign inc_total  = (base_total == COUNT_MAX) ? base_total : base_total + 1'b1;

  always_comb begin
    if (fault) begin
      count_out = slot_ok ? inc_total : '0;
    end else begin
      count_out = own_hit ? own_total : '0;
    end
    if (served && hit) begin
      idx_out = IXW'(hit_idx);
    end else if (alloc) begin
      idx_out = IXW'(occ);
    end else begin
      idx_out = '0;
    end
  end

  pfta_ram #(.WIDTH(FW), .DEPTH(FRAME_COUNT)) u_frame_ram (
    .clk   (clk),
    .we    (commit && alloc),
    .waddr (occ[FAW-1:0]),
    .wdata ({pid, page}),
    .raddr (f_issue[FAW-1:0]),
    .rdata (fr_rdata)
  );

  pfta_ram #(.WIDTH(TW), .DEPTH(PROCESS_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (commit && fault && slot_ok),
    .waddr (use_slot),
    .wdata ({pid, inc_total}),
    .raddr (s_issue[SAW-1:0]),
    .rdata (sl_rdata)
  );

  // recency stamps, written on every served request that names a frame
  pfta_ram #(.WIDTH(STAMP_W), .DEPTH(FRAME_COUNT)) u_stamp_ram (
    .clk   (clk),
    .we    (commit && served && (hit || alloc)),
    .waddr (idx_out[FAW-1:0]),
    .wdata (stamp),
    .raddr (hit_idx),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occ        <= '0;
      max_occ    <= MAX_OCC_RESET;
      stamp      <= STAMP_RESET;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
      f_pend     <= 1'b0;
      s_pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_occ <= cfg_data;
      end

      // a commit reloads the output register in the same cycle
      if (rsp_valid && !rsp_stall && !commit) begin
        rsp_valid <= 1'b0;
      end

      f_pend <= f_rd;
      s_pend <= s_rd;
      if (f_rd) begin
        f_pidx  <= f_issue[FAW-1:0];
        f_issue <= f_issue + 1'b1;
      end
      if (s_rd) begin
        s_pidx  <= s_issue[SAW-1:0];
        s_pval  <= slot_valid[s_issue[SAW-1:0]];
        s_issue <= s_issue + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            pid     <= req.process_id;
            page    <= req.page_number;
            refuse  <= refuse_now;
            hit     <= 1'b0;
            hit_idx <= '0;
            own_hit <= 1'b0;
            emp_hit <= 1'b0;
            f_issue <= '0;
            s_issue <= '0;
            state   <= (refuse_now || (occ == '0)) ? ST_SLOT : ST_FRAME;
          end
        end
        ST_FRAME: begin
          if (f_pend && !hit && (fr_rdata == {pid, page})) begin
            hit     <= 1'b1;
            hit_idx <= f_pidx;
          end
          if (!f_rd && !f_pend) begin
            state <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          if (s_pend) begin
            if (!own_hit && (sl_owner == pid)) begin
              own_hit   <= 1'b1;
              own_idx   <= s_pidx;
              own_total <= sl_total;
            end
            if (!emp_hit && (sl_owner == '0)) begin
              emp_hit   <= 1'b1;
              emp_idx   <= s_pidx;
              emp_total <= sl_total;
            end
          end
          if (!s_rd && !s_pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.refused     <= refuse;
            rsp.hit         <= served && hit;
            rsp.allocated   <= alloc;
            rsp.frame_index <= idx_out[IDX_W-1:0];
            rsp.fault_count <= count_out;
            rsp.occupancy   <= alloc ? OCC_W'(occ + 1'b1) : occ[OCC_W-1:0];
            if (alloc) begin
              occ <= occ + 1'b1;
            end
            if (fault && slot_ok) begin
              slot_valid[use_slot] <= 1'b1;
            end
            if (served) begin
              stamp <= stamp + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pfta_checker.sv =====
module pfta_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input pfta_pkg::rsp_t rsp
);

  import pfta_pkg::*;

  logic [OCC_W-1:0] last_occ;
  logic             rsp_take;

  assign rsp_take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_occ <= '0;
    end else if (rsp_take) begin
      last_occ <= rsp.occupancy;
    end
  end

  // one request in flight: the port closes right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request port open right after a request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.allocated)
                  && !(rsp.refused && (rsp.hit || rsp.allocated)))
    else $error("conflicting response outcome");

  a_occ_alloc: assert property (@(posedge clk) disable iff (rst)
    rsp_take && rsp.allocated |-> rsp.occupancy == OCC_W'(last_occ + 1'b1))
    else $error("allocation did not add one frame");

  a_occ_keep: assert property (@(posedge clk) disable iff (rst)
    rsp_take && !rsp.allocated |-> rsp.occupancy == last_occ)
    else $error("occupancy moved without allocation");

endmodule

bind page_frame_table_allocator pfta_checker u_pfta_checker (.*);
